### src/lidar_polar_to_cartesian_unit_defines.svh
// Assertion macros for the lidar polar-to-Cartesian unit.
// Expects clock and reset to be in scope where a macro is used.
`ifndef LIDAR_POLAR_TO_CARTESIAN_UNIT_DEFINES_SVH
`define LIDAR_POLAR_TO_CARTESIAN_UNIT_DEFINES_SVH

// same-cycle implication
`define LPC_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lpc: implication check failed");

// delayed implication; n sets the delay
`define LPC_ASSERT_AFTER(lbl, ante, n, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##(n) (cons)) \
      else $error("lpc: delayed check failed");

`endif

### src/lpc_pkg.sv
// Shared types, constants and arithmetic helpers for the lidar polar-to-Cartesian unit.
// No dependencies.
package lpc_pkg;

   localparam int LPC_MAX_SAMPLES_DEF = 2048;
   localparam int LPC_IDX_LIMIT_W     = 17;

   // CSR register indexes
   localparam logic [1:0] CSR_RANGE_MIN   = 2'd0;
   localparam logic [1:0] CSR_RANGE_MAX   = 2'd1;
   localparam logic [1:0] CSR_START_ANGLE = 2'd2;
   localparam logic [1:0] CSR_ANGLE_STEP  = 2'd3;

   localparam logic [15:0] RANGE_MIN_RST   = 16'd20;
   localparam logic [15:0] RANGE_MAX_RST   = 16'd65535;
   localparam logic [15:0] START_ANGLE_RST = 16'd0;
   localparam logic [11:0] ANGLE_STEP_RST  = 12'd0;

   // CORDIC: Q4.30 datapath, two iterations per pipeline stage
   localparam int CW              = 34;
   localparam int CORDIC_ITERS    = 16;
   localparam int ITERS_PER_STAGE = 2;
   localparam int CORDIC_STAGES   = CORDIC_ITERS / ITERS_PER_STAGE;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

   // accept edge to result edge
   localparam int LPC_LATENCY = CORDIC_STAGES + 4;

   typedef struct packed {
      logic [15:0] range_mm;
      logic        gate;
      logic        scan_end;
   } lpc_side_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } lpc_rot_type;

   function automatic logic signed [CW-1:0] lpc_atan(input int i);
      logic signed [CW-1:0] a;
      case (i)
         0:       a = 34'sd536870912;
         1:       a = 34'sd316933406;
         2:       a = 34'sd167458907;
         3:       a = 34'sd85004756;
         4:       a = 34'sd42667331;
         5:       a = 34'sd21354465;
         6:       a = 34'sd10679838;
         7:       a = 34'sd5340245;
         8:       a = 34'sd2670163;
         9:       a = 34'sd1335087;
         10:      a = 34'sd667544;
         11:      a = 34'sd333772;
         12:      a = 34'sd166886;
         13:      a = 34'sd83443;
         14:      a = 34'sd41722;
         15:      a = 34'sd20861;
         default: a = '0;
      endcase
      return a;
   endfunction

   // one CORDIC micro-rotation
   function automatic lpc_rot_type lpc_rotate(input lpc_rot_type v, input int i);
      lpc_rot_type          r;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      dx = $signed(v.y) >>> i;
      dy = $signed(v.x) >>> i;
      if (!v.z[CW-1]) begin
         r.x = v.x - dx;
         r.y = v.y + dy;
         r.z = v.z - lpc_atan(i);
      end else begin
         r.x = v.x + dx;
         r.y = v.y - dy;
         r.z = v.z + lpc_atan(i);
      end
      return r;
   endfunction

   // round Q4.30 to Q1.15, clamp symmetric, undo the half-turn fold
   function automatic logic signed [15:0] lpc_to_q15(input logic signed [CW-1:0] v,
                                                     input logic neg);
      logic signed [CW-1:0] r;
      r = (v + 34'sd16384) >>> 15;
      if (r > 34'sd32767) begin
         r = 34'sd32767;
      end else if (r < -34'sd32767) begin
         r = -34'sd32767;
      end
      if (neg) begin
         r = -r;
      end
      return r[15:0];
   endfunction

   // product >> 15, truncated toward zero
   function automatic logic signed [16:0] lpc_trunc(input logic signed [32:0] p);
      logic signed [32:0] t;
      t = p + (p[32] ? 33'sd32767 : 33'sd0);
      t = t >>> 15;
      return t[16:0];
   endfunction

endpackage

### src/lpc_front.sv
// Front stage: CSR registers, beam angle computation and range and sample-index gate.
// Depends on lpc_pkg.
module lpc_front import lpc_pkg::*; #(
   parameter int MAX_SAMPLES = LPC_MAX_SAMPLES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata,
   input  logic         in_vld,
   input  logic [10:0]  in_sample_index,
   input  logic [15:0]  in_range_mm,
   input  logic         in_scan_end,
   output logic         out_vld,
   output logic [15:0]  out_angle,
   output lpc_side_type out_side
);

   localparam logic [LPC_IDX_LIMIT_W-1:0] IDX_LIMIT = LPC_IDX_LIMIT_W'(MAX_SAMPLES);

   logic [15:0]  range_min_ff;
   logic [15:0]  range_max_ff;
   logic [15:0]  start_angle_ff;
   logic [11:0]  angle_step_ff;

   logic [22:0]  prod_in;
   logic [15:0]  angle_in;
   logic         gate_in;

   logic         vld_ff;
   logic [15:0]  angle_ff;
   lpc_side_type side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_ff   <= RANGE_MIN_RST;
         range_max_ff   <= RANGE_MAX_RST;
         start_angle_ff <= START_ANGLE_RST;
         angle_step_ff  <= ANGLE_STEP_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RANGE_MIN:   range_min_ff   <= csr_wdata;
            CSR_RANGE_MAX:   range_max_ff   <= csr_wdata;
            CSR_START_ANGLE: start_angle_ff <= csr_wdata;
            CSR_ANGLE_STEP:  angle_step_ff  <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // angle wraps modulo one turn
   assign prod_in  = {12'd0, in_sample_index} * {11'd0, angle_step_ff};
   assign angle_in = start_angle_ff + prod_in[15:0];
   assign gate_in  = (in_range_mm > range_min_ff) && (in_range_mm < range_max_ff) &&
                     ({{(LPC_IDX_LIMIT_W-11){1'b0}}, in_sample_index} < IDX_LIMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      angle_ff          <= angle_in;
      side_ff.range_mm  <= in_range_mm;
      side_ff.gate      <= gate_in;
      side_ff.scan_end  <= in_scan_end;
   end

   assign out_vld   = vld_ff;
   assign out_angle = angle_ff;
   assign out_side  = side_ff;

endmodule

### src/lpc_cordic.sv
// Pipelined CORDIC sine/cosine: half-plane fold, two rotations per stage, Q1.15 rounding.
// Depends on lpc_pkg.
module lpc_cordic import lpc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_vld,
   input  logic [15:0]        in_angle,
   input  lpc_side_type       in_side,
   output logic               out_vld,
   output logic signed [15:0] out_cos,
   output logic signed [15:0] out_sin,
   output lpc_side_type       out_side
);

   lpc_rot_type  rot_ff  [CORDIC_STAGES];
   logic         vld_ff  [CORDIC_STAGES];
   logic         neg_ff  [CORDIC_STAGES];
   lpc_side_type side_ff [CORDIC_STAGES];

   logic               rnd_vld_ff;
   logic signed [15:0] cos_ff;
   logic signed [15:0] sin_ff;
   lpc_side_type       rnd_side_ff;

   for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stg
      lpc_rot_type  rot_a;
      lpc_rot_type  rot_b;
      lpc_rot_type  rot_in;
      logic         vld_a;
      logic         neg_a;
      lpc_side_type side_a;

      if (s == 0) begin : g_first
         // fold the left half-plane onto the right; negate both results later
         always_comb begin
            logic [15:0] ang_f;
            neg_a   = in_angle[15] ^ in_angle[14];
            ang_f   = in_angle ^ {neg_a, 15'd0};
            rot_a.x = CORDIC_GAIN;
            rot_a.y = '0;
            rot_a.z = {{2{ang_f[15]}}, ang_f, 16'd0};
            vld_a   = in_vld;
            side_a  = in_side;
         end
      end else begin : g_next
         assign rot_a  = rot_ff[s-1];
         assign vld_a  = vld_ff[s-1];
         assign neg_a  = neg_ff[s-1];
         assign side_a = side_ff[s-1];
      end

      assign rot_b  = lpc_rotate(rot_a, ITERS_PER_STAGE * s);
      assign rot_in = lpc_rotate(rot_b, ITERS_PER_STAGE * s + 1);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_a;
         end
      end

      always_ff @(posedge clock) begin
         rot_ff[s]  <= rot_in;
         neg_ff[s]  <= neg_a;
         side_ff[s] <= side_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_vld_ff <= 1'b0;
      end else begin
         rnd_vld_ff <= vld_ff[CORDIC_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      cos_ff      <= lpc_to_q15(rot_ff[CORDIC_STAGES-1].x, neg_ff[CORDIC_STAGES-1]);
      sin_ff      <= lpc_to_q15(rot_ff[CORDIC_STAGES-1].y, neg_ff[CORDIC_STAGES-1]);
      rnd_side_ff <= side_ff[CORDIC_STAGES-1];
   end

   assign out_vld  = rnd_vld_ff;
   assign out_cos  = cos_ff;
   assign out_sin  = sin_ff;
   assign out_side = rnd_side_ff;

endmodule

### src/lpc_scale.sv
// Range scaling: multiply by Q1.15 sine/cosine, truncate toward zero, gate to zero.
// Depends on lpc_pkg.
module lpc_scale import lpc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_vld,
   input  logic signed [15:0] in_cos,
   input  logic signed [15:0] in_sin,
   input  lpc_side_type       in_side,
   output logic               out_vld,
   output logic signed [16:0] out_x_mm,
   output logic signed [16:0] out_y_mm,
   output logic               out_point_valid,
   output logic               out_scan_end
);

   logic signed [32:0] px_in;
   logic signed [32:0] py_in;

   logic               mul_vld_ff;
   logic signed [32:0] px_ff;
   logic signed [32:0] py_ff;
   lpc_side_type       mul_side_ff;

   logic               vld_ff;
   logic signed [16:0] x_ff;
   logic signed [16:0] y_ff;
   logic               valid_ff;
   logic               end_ff;

   assign px_in = $signed({1'b0, in_side.range_mm}) * in_cos;
   assign py_in = $signed({1'b0, in_side.range_mm}) * in_sin;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
         vld_ff     <= 1'b0;
      end else begin
         mul_vld_ff <= in_vld;
         vld_ff     <= mul_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      py_ff       <= py_in;
      mul_side_ff <= in_side;
      // drop coordinates of a gated point
      x_ff        <= mul_side_ff.gate ? lpc_trunc(px_ff) : 17'sd0;
      y_ff        <= mul_side_ff.gate ? lpc_trunc(py_ff) : 17'sd0;
      valid_ff    <= mul_side_ff.gate;
      end_ff      <= mul_side_ff.scan_end;
   end

   assign out_vld         = vld_ff;
   assign out_x_mm        = x_ff;
   assign out_y_mm        = y_ff;
   assign out_point_valid = valid_ff;
   assign out_scan_end    = end_ff;

endmodule

### src/lidar_polar_to_cartesian_unit.sv
// Lidar polar-to-Cartesian unit: one scan sample in, one x/y point out.
// A sample accepted on start && !busy passes the front register, the 8 CORDIC stages
// and the rounding, product and output registers; rsp_strobe marks the result.
// Throughput: one sample per cycle; busy is low whenever reset is low.
// Reset (synchronous): clears the pipeline valid bits and loads the CSR defaults.
module lidar_polar_to_cartesian_unit import lpc_pkg::*; #(
   parameter int MAX_SAMPLES = LPC_MAX_SAMPLES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [10:0]        req_sample_index,
   input  logic [15:0]        req_range_mm,
   input  logic               req_scan_end,
   output logic               rsp_strobe,
   output logic signed [16:0] rsp_x_mm,
   output logic signed [16:0] rsp_y_mm,
   output logic               rsp_point_valid,
   output logic               rsp_scan_end_out,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   logic               front_vld;
   logic [15:0]        front_angle;
   lpc_side_type       front_side;

   logic               cord_vld;
   logic signed [15:0] cord_cos;
   logic signed [15:0] cord_sin;
   lpc_side_type       cord_side;

   assign busy      = reset;
   assign csr_ready = !reset;

   lpc_front #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .in_vld          (start && !busy),
      .in_sample_index (req_sample_index),
      .in_range_mm     (req_range_mm),
      .in_scan_end     (req_scan_end),
      .out_vld         (front_vld),
      .out_angle       (front_angle),
      .out_side        (front_side)
   );

   lpc_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (front_vld),
      .in_angle (front_angle),
      .in_side  (front_side),
      .out_vld  (cord_vld),
      .out_cos  (cord_cos),
      .out_sin  (cord_sin),
      .out_side (cord_side)
   );

   lpc_scale u_scale (
      .clock           (clock),
      .reset           (reset),
      .in_vld          (cord_vld),
      .in_cos          (cord_cos),
      .in_sin          (cord_sin),
      .in_side         (cord_side),
      .out_vld         (rsp_strobe),
      .out_x_mm        (rsp_x_mm),
      .out_y_mm        (rsp_y_mm),
      .out_point_valid (rsp_point_valid),
      .out_scan_end    (rsp_scan_end_out)
   );

endmodule

### src/lpc_checker.sv
// Port-level checks for the lidar polar-to-Cartesian unit, bound to the top level.
// Depends on lpc_pkg and lidar_polar_to_cartesian_unit_defines.svh.
`include "lidar_polar_to_cartesian_unit_defines.svh"

module lpc_checker import lpc_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               req_scan_end,
   input logic               rsp_strobe,
   input logic signed [16:0] rsp_x_mm,
   input logic signed [16:0] rsp_y_mm,
   input logic               rsp_point_valid,
   input logic               rsp_scan_end_out
);

   // every transfer in yields a result on rsp_strobe
   `LPC_ASSERT_AFTER(a_latency_fwd, start && !busy, LPC_LATENCY, rsp_strobe)

   // no result without a matching transfer in
   `LPC_ASSERT_IMPL(a_latency_back, rsp_strobe, $past(start && !busy, LPC_LATENCY))

   // the scan end mark stays aligned with its sample
   `LPC_ASSERT_IMPL(a_end_aligned, rsp_strobe,
                    rsp_scan_end_out == $past(req_scan_end, LPC_LATENCY))

   // gated points carry zero coordinates
   `LPC_ASSERT_IMPL(a_gated_zero, rsp_strobe && !rsp_point_valid,
                    rsp_x_mm == 17'sd0 && rsp_y_mm == 17'sd0)

endmodule

bind lidar_polar_to_cartesian_unit lpc_checker u_lpc_checker (.*);

### tb/lidar_polar_to_cartesian_unit_point_check.sv
// Point check for the lidar polar-to-Cartesian unit: mirrors the CSRs, predicts each point
// and compares it with the rsp_* transfer. Depends on lpc_pkg for register codes and resets.
module lidar_polar_to_cartesian_unit_point_check import lpc_pkg::*; #(
   parameter int MAX_SAMPLES = LPC_MAX_SAMPLES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [10:0]        req_sample_index,
   input  logic [15:0]        req_range_mm,
   input  logic               req_scan_end,
   input  logic               rsp_strobe,
   input  logic signed [16:0] rsp_x_mm,
   input  logic signed [16:0] rsp_y_mm,
   input  logic               rsp_point_valid,
   input  logic               rsp_scan_end_out,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   output int                 fail_count,
   output int                 pending
);

   localparam longint GAIN_Q30 = 652032874;

   typedef struct packed {
      logic signed [16:0] x_mm;
      logic signed [16:0] y_mm;
      logic               point_valid;
      logic               scan_end;
   } point_type;

   logic [15:0] gate_floor;
   logic [15:0] gate_ceil;
   logic [15:0] start_angle;
   logic [11:0] angle_step;
   point_type   points_due[$];

   function automatic longint atan_q30(input int i);
      longint a;
      case (i)
         0:       a = 536870912;
         1:       a = 316933406;
         2:       a = 167458907;
         3:       a = 85004756;
         4:       a = 42667331;
         5:       a = 21354465;
         6:       a = 10679838;
         7:       a = 5340245;
         8:       a = 2670163;
         9:       a = 1335087;
         10:      a = 667544;
         11:      a = 333772;
         12:      a = 166886;
         13:      a = 83443;
         14:      a = 41722;
         default: a = 20861;
      endcase
      return a;
   endfunction

   function automatic int round_q15(input longint v);
      longint r;
      r = (v + 64'sd16384) >>> 15;
      if (r > 32767) begin
         r = 32767;
      end else if (r < -32767) begin
         r = -32767;
      end
      return int'(r);
   endfunction

   function automatic void beam_sin_cos(input logic [15:0] angle, output int s, output int c);
      logic [15:0] folded;
      logic        flip;
      longint      x, y, z, dx, dy;
      folded = angle;
      flip   = 1'b0;
      // fold the back half-plane forward; both results change sign
      if (folded >= 16'h4000 && folded < 16'hC000) begin
         folded = folded ^ 16'h8000;
         flip   = 1'b1;
      end
      z = longint'($signed(folded)) * 65536;
      x = GAIN_Q30;
      y = 0;
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - atan_q30(i);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + atan_q30(i);
         end
      end
      c = round_q15(x);
      s = round_q15(y);
      if (flip) begin
         c = -c;
         s = -s;
      end
   endfunction

   // range times Q1.15, truncated toward zero
   function automatic logic signed [16:0] scale_q15(input logic [15:0] rng, input int q);
      longint p;
      longint t;
      p = longint'(rng) * longint'(q);
      if (p < 0) begin
         t = -((-p) >>> 15);
      end else begin
         t = p >>> 15;
      end
      return t[16:0];
   endfunction

   function automatic point_type predict_point(input logic [10:0] idx, input logic [15:0] rng,
                                               input logic last);
      point_type   pt;
      logic [31:0] sweep;
      int          s, c;
      pt.point_valid = (rng > gate_floor) && (rng < gate_ceil) && (int'(idx) < MAX_SAMPLES);
      pt.scan_end    = last;
      pt.x_mm        = '0;
      pt.y_mm        = '0;
      if (pt.point_valid) begin
         sweep = 32'(start_angle) + 32'(idx) * 32'(angle_step);
         beam_sin_cos(sweep[15:0], s, c);
         pt.x_mm = scale_q15(rng, c);
         pt.y_mm = scale_q15(rng, s);
      end
      return pt;
   endfunction

   always @(posedge clock) begin
      point_type due;
      if (reset) begin
         gate_floor  = RANGE_MIN_RST;
         gate_ceil   = RANGE_MAX_RST;
         start_angle = START_ANGLE_RST;
         angle_step  = ANGLE_STEP_RST;
         points_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RANGE_MIN:   gate_floor  = csr_wdata;
               CSR_RANGE_MAX:   gate_ceil   = csr_wdata;
               CSR_START_ANGLE: start_angle = csr_wdata;
               CSR_ANGLE_STEP:  angle_step  = csr_wdata[11:0];
               default: ;
            endcase
         end
         if (rsp_strobe) begin
            if (points_due.size() == 0) begin
               $error("point with no sample outstanding: x_mm %0d y_mm %0d",
                      rsp_x_mm, rsp_y_mm);
               fail_count = fail_count + 1;
            end else begin
               due = points_due.pop_front();
               if (rsp_x_mm !== due.x_mm) begin
                  $error("x_mm: expected %0d, got %0d", due.x_mm, rsp_x_mm);
                  fail_count = fail_count + 1;
               end
               if (rsp_y_mm !== due.y_mm) begin
                  $error("y_mm: expected %0d, got %0d", due.y_mm, rsp_y_mm);
                  fail_count = fail_count + 1;
               end
               if (rsp_point_valid !== due.point_valid) begin
                  $error("point_valid: expected %0d, got %0d", due.point_valid,
                         rsp_point_valid);
                  fail_count = fail_count + 1;
               end
               if (rsp_scan_end_out !== due.scan_end) begin
                  $error("scan_end_out: expected %0d, got %0d", due.scan_end,
                         rsp_scan_end_out);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (start && !busy) begin
            points_due.insert(points_due.size(),
                              predict_point(req_sample_index, req_range_mm, req_scan_end));
         end
      end
      pending = points_due.size();
   end

endmodule

### tb/lidar_polar_to_cartesian_unit_tb.sv
// Testbench top for the lidar polar-to-Cartesian unit: drives scan samples and CSR writes,
// and gives the verdict. Depends on lpc_pkg, the unit and its point check module.
module lidar_polar_to_cartesian_unit_tb;
   import lpc_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int SCAN_PHASES   = 9;
   localparam int PHASE_SAMPLES = 137;

   bit                 clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [10:0]        req_sample_index;
   logic [15:0]        req_range_mm;
   logic               req_scan_end;
   logic               rsp_strobe;
   logic signed [16:0] rsp_x_mm;
   logic signed [16:0] rsp_y_mm;
   logic               rsp_point_valid;
   logic               rsp_scan_end_out;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [15:0]        csr_wdata;

   int          fail_count;
   int          pending;
   int          idle_pct;
   logic [15:0] gate_lo;
   logic [15:0] gate_hi;

   lidar_polar_to_cartesian_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_sample_index (req_sample_index),
      .req_range_mm     (req_range_mm),
      .req_scan_end     (req_scan_end),
      .rsp_strobe       (rsp_strobe),
      .rsp_x_mm         (rsp_x_mm),
      .rsp_y_mm         (rsp_y_mm),
      .rsp_point_valid  (rsp_point_valid),
      .rsp_scan_end_out (rsp_scan_end_out),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   lidar_polar_to_cartesian_unit_point_check point_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_sample_index (req_sample_index),
      .req_range_mm     (req_range_mm),
      .req_scan_end     (req_scan_end),
      .rsp_strobe       (rsp_strobe),
      .rsp_x_mm         (rsp_x_mm),
      .rsp_y_mm         (rsp_y_mm),
      .rsp_point_valid  (rsp_point_valid),
      .rsp_scan_end_out (rsp_scan_end_out),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         return $urandom_range(1, 18);
      end
      return 0;
   endfunction

   // aim half of the ranges at the gate edges and the field extremes
   function automatic logic [15:0] pick_range();
      case ($urandom_range(0, 7))
         0:       return gate_lo + 16'($urandom_range(0, 2)) - 16'd1;
         1:       return gate_hi + 16'($urandom_range(0, 2)) - 16'd1;
         2:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         3:       return gate_lo + 16'($urandom_range(0, 300));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_sample(input logic [10:0] idx, input logic [15:0] rng,
                              input logic last);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start            <= 1'b1;
      req_sample_index <= idx;
      req_range_mm     <= rng;
      req_scan_end     <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         csr_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // drop start, then hold until every point is back and the pipe has gone quiet
   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (LPC_LATENCY + 4) @(negedge clock);
   endtask

   task automatic load_config(input logic [15:0] lo, input logic [15:0] hi,
                              input logic [15:0] angle0, input logic [11:0] step);
      settle();
      write_reg(CSR_RANGE_MIN, lo);
      write_reg(CSR_RANGE_MAX, hi);
      write_reg(CSR_START_ANGLE, angle0);
      write_reg(CSR_ANGLE_STEP, {4'b0000, step});
      @(negedge clock);
      csr_valid <= 1'b0;
      gate_lo = lo;
      gate_hi = hi;
   endtask

   // mostly whole scans with random ranges; a few stray samples and cut or offset scans
   task automatic run_scans(input int count, input bit allow_idle);
      int          sent;
      int          scan_len;
      logic [10:0] first;
      sent = 0;
      while (sent < count) begin
         idle_pct = 0;
         if (allow_idle) begin
            case ($urandom_range(0, 3))
               0:       idle_pct = 0;
               1:       idle_pct = 5;
               2:       idle_pct = 25;
               default: idle_pct = 60;
            endcase
         end
         if ($urandom_range(0, 7) == 0) begin
            send_sample(11'($urandom), pick_range(), 1'($urandom));
            sent++;
         end else begin
            scan_len = ($urandom_range(0, 15) == 0) ? $urandom_range(65, 300)
                                                    : $urandom_range(1, 48);
            first = ($urandom_range(0, 7) == 0) ? 11'($urandom) : 11'd0;
            for (int pos = 0; pos < scan_len && sent < count; pos++) begin
               send_sample(first + 11'(pos), pick_range(), pos == scan_len - 1);
               sent++;
            end
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_sample_index = '0;
      req_range_mm     = '0;
      req_scan_end     = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = CSR_RANGE_MIN;
      csr_wdata        = '0;
      idle_pct         = 0;
      gate_lo          = RANGE_MIN_RST;
      gate_hi          = RANGE_MAX_RST;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // gate edges and index extremes under the reset settings
      idle_pct = 20;
      send_sample(11'd0, 16'd0, 1'b0);
      send_sample(11'd0, 16'd20, 1'b0);
      send_sample(11'd0, 16'd21, 1'b1);
      send_sample(11'd2047, 16'd65534, 1'b0);
      send_sample(11'd2047, 16'd65535, 1'b1);

      // fold boundaries at a quarter and three quarters of a turn
      load_config(16'd0, 16'hFFFF, 16'h3FFF, 12'd1);
      send_sample(11'd0, 16'd65534, 1'b0);
      send_sample(11'd1, 16'd65534, 1'b0);
      send_sample(11'd1, 16'd1, 1'b1);
      load_config(16'd0, 16'hFFFF, 16'hBFFF, 12'd1);
      send_sample(11'd0, 16'd30000, 1'b0);
      send_sample(11'd1, 16'd30000, 1'b1);

      // most negative start angle, widest step, wrapping sweep
      load_config(16'd0, 16'hFFFF, 16'h8000, 12'hFFF);
      send_sample(11'd0, 16'd65534, 1'b0);
      send_sample(11'd1, 16'd12345, 1'b0);
      send_sample(11'd2047, 16'd65534, 1'b1);

      // one-wide and inverted gates pass nothing
      load_config(16'd100, 16'd101, 16'h7FFF, 12'd7);
      send_sample(11'd3, 16'd100, 1'b0);
      send_sample(11'd3, 16'd101, 1'b0);
      send_sample(11'd3, 16'd99, 1'b1);
      load_config(16'hFFFF, 16'd0, 16'd0, 12'd0);
      send_sample(11'd0, 16'hFFFF, 1'b0);
      send_sample(11'd0, 16'd0, 1'b1);

      for (int phase = 0; phase < SCAN_PHASES; phase++) begin
         logic [15:0] lo;
         logic [15:0] hi;
         logic [11:0] step;
         idle_pct = (phase == SCAN_PHASES - 1) ? 0 : 20;
         lo = 16'($urandom_range(0, 3000));
         hi = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(lo + 2, 65535));
         case ($urandom_range(0, 3))
            0:       step = 12'd0;
            1:       step = 12'hFFF;
            default: step = 12'($urandom);
         endcase
         if (phase == 0) begin
            load_config(16'd0, 16'hFFFF, 16'h7FFF, 12'hFFF);
         end else begin
            load_config(lo, hi, 16'($urandom), step);
         end
         run_scans(PHASE_SAMPLES, phase != SCAN_PHASES - 1);
      end

      settle();
      if (fail_count == 0) begin
         $display("PASS lidar_polar_to_cartesian_unit");
      end else begin
         $display("FAIL lidar_polar_to_cartesian_unit");
      end
      $finish;
   end

   // end the run if no transfer of any kind happens for too long
   initial begin
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("FAIL lidar_polar_to_cartesian_unit");
      $finish;
   end

endmodule
